### rtl/bdq_pkg.sv
// Shared definitions for the bounded deque with search.
// Holds op and status codes, the controller state type and the control/status structs.
// No dependencies.
package bdq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_FRONT = 3'd2;
  localparam logic [2:0] OP_REM_BACK  = 3'd3;
  localparam logic [2:0] OP_SEARCH    = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch op and value of an accepted request
    logic apply;        // do a queue op (or trivial search) and post its result
    logic search_init;  // point the scan at the front entry
    logic scan;         // issue one entry read of the scan
    logic finish;       // post the search result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_needed;  // search on a non-empty store
    logic hit;          // entry under compare matches
    logic last;         // entry under compare is the last stored one
  } stat_t;

endpackage

### rtl/bdq_ctrl.sv
// Controller state machine for the bounded deque with search.
// Depends on bdq_pkg.
module bdq_ctrl import bdq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.scan_needed) begin
          cmd.search_init = 1'b1;
          state_next      = S_SCAN;
        end else begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // stop issuing once the compare stage decides
        if (stat.hit || stat.last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/bdq_dp.sv
// Datapath for the bounded deque with search: ring store, front index, count,
// scan pointer with registered read and compare, and result registers. Depends on bdq_pkg.
module bdq_dp import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  op,
  input  logic signed [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  position,
  output logic [4:0]  occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);

  logic [31:0]   mem [DEPTH];

  logic [2:0]    op_q;
  logic [31:0]   value_q;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] k, k_d;
  logic          rd_valid;
  logic [31:0]   rd_data;

  logic          full, empty, issue;
  logic [AW:0]   back_sum;
  logic [AW-1:0] back_idx, front_dec, front_inc, ptr_inc;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    st;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);

  assign back_sum  = {1'b0, front} + (AW+1)'(count);
  assign back_idx  = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : back_sum[AW-1:0];
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
  assign front_inc = (front == LAST_IDX) ? '0 : front + 1'b1;
  assign ptr_inc   = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;

  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = back_idx;
    st         = ST_DONE;
    case (op_q)
      OP_INS_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          front_next = front_dec;
          wr_addr    = front_dec;
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_INS_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      OP_REM_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      OP_SEARCH: begin
        if (empty) st = ST_EMPTY;
      end
      default: st = ST_DONE;
    endcase
  end

  assign issue            = cmd.scan && (k < count);
  assign stat.scan_needed = (op_q == OP_SEARCH) && !empty;
  assign stat.hit         = rd_valid && (rd_data == value_q);
  assign stat.last        = rd_valid && (k_d == count - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en && cmd.apply) begin
      mem[wr_addr] <= value_q;
    end
    if (issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      value_q <= value;
    end
    if (cmd.search_init) begin
      rd_ptr <= front;
      k      <= '0;
    end else if (issue) begin
      rd_ptr <= ptr_inc;
      k      <= k + 1'b1;
    end
    k_d <= k;
    if (cmd.apply) begin
      status    <= st;
      position  <= '0;
      occupancy <= 5'(count_next);
    end else if (cmd.finish) begin
      status    <= stat.hit ? ST_DONE : ST_NOTFOUND;
      position  <= stat.hit ? 5'(k_d + 1'b1) : 5'd0;
      occupancy <= 5'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cmd.apply) begin
        front <= front_next;
        count <= count_next;
      end
      rd_valid <= issue;
      done     <= cmd.apply || cmd.finish;
    end
  end

endmodule

### rtl/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_dp.
//
//   channel   | ports                          | handshake
//   ----------+--------------------------------+-------------------------------
//   request   | op[2:0], value[31:0] signed    | taken when start && !busy
//   result    | status[1:0], position[4:0],    | shown for one cycle with done,
//             | occupancy[4:0]                 | receiver cannot stall
//
// Sequence: an insert or remove (and a search on an empty store) is captured,
// then applied in S_EXEC, with done registered from the apply. A search
// compares m entries in S_SCAN, m being the 1-based match position, or the
// stored count on a miss; the single read port of the ring store reads one
// entry a cycle. A new request may be taken in the cycle done is shown.
// Reset (rst, synchronous) empties the deque; store contents are not cleared.
module bounded_deque_with_search_top import bdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic [4:0]         position,
  output logic [4:0]         occupancy
);

  cmd_t  cmd;   // controller -> datapath
  stat_t stat;  // datapath -> controller

  // Sequence each request: capture, then apply or scan, then post result.
  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the ring store, indexes, scan pipeline and result registers.
  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .value     (value),
    .done      (done),
    .status    (status),
    .position  (position),
    .occupancy (occupancy)
  );

endmodule

### rtl/bdq_chk.sv
// Port-level checker for the bounded deque with search, bound to the top level.
// Depends on bdq_pkg and bounded_deque_with_search_top.
module bdq_chk import bdq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  op,
  input logic [31:0] value,
  input logic        done,
  input logic [1:0]  status,
  input logic [4:0]  position,
  input logic [4:0]  occupancy
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy)) else $error("result not at end of busy period");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start)) else $error("busy rose without a request");

  a_pos_status: assert property (@(posedge clk) disable iff (rst)
    done && (position != 5'd0) |-> status == ST_DONE)
    else $error("nonzero position without success status");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> occupancy == 5'd0)
    else $error("empty status with nonzero occupancy");

endmodule

bind bounded_deque_with_search_top bdq_chk u_chk (.*);
